// File: hdl/mandelbrot_coordinate_warp_macros.svh
// assertion macros for the coordinate warp pipeline
// used by the top level only
`ifndef MANDELBROT_COORDINATE_WARP_MACROS_SVH
`define MANDELBROT_COORDINATE_WARP_MACROS_SVH
// property p must hold at every clock edge out of reset
`define MCW_ASSERT(label, clk, rst_n, p, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);
// implication a |=> b
`define MCW_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// File: hdl/mcw_pkg.sv
// shared types, constants and arithmetic helpers for the coordinate warp
// no dependencies
package mcw_pkg;
	localparam int WORD_W = 36;
	localparam int COORD_W = 14;
	localparam int FRAC_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 36;
	localparam int QW = 80;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_BASE = 3'd0,
		REG_Y_BASE = 3'd1,
		REG_X_STEP = 3'd2,
		REG_Y_STEP = 3'd3,
		REG_DEPTH  = 3'd4,
		REG_MODE   = 3'd5,
		REG_WIDTH  = 3'd6,
		REG_HEIGHT = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OUT_SAMPLE = 2'd0,
		OUT_TRANSP = 2'd1,
		OUT_BLACK  = 2'd2,
		OUT_WHITE  = 2'd3
	} outcome_t;

	localparam word_t Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// saturate a wide signed value to the word range
	function automatic word_t sat_w(input logic signed [QW-1:0] v, output logic ovf);
		ovf = 1'b0;
		if (v > QW'(signed'(Q_MAX))) begin
			ovf = 1'b1;
			return Q_MAX;
		end
		if (v < QW'(signed'(Q_MIN))) begin
			ovf = 1'b1;
			return Q_MIN;
		end
		return v[WORD_W-1:0];
	endfunction
endpackage

// File: hdl/mcw_if.sv
// valid/ready channel interface with a generic payload
// depends on nothing
interface mcw_if #(parameter int W = 1) (input logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/mcw_cfg_if.sv
// configuration write channel: register index and data
// depends on mcw_pkg
interface mcw_cfg_if import mcw_pkg::*; (input logic clk);
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: hdl/mcw_iter.sv
// one unrolled mandelbrot update in three register stages
// depends on mcw_pkg; stalls by a shared enable
module mcw_iter import mcw_pkg::*; #(
	parameter int FRAC_BITS = 24
) (
	input  logic  clk,
	input  logic  en,
	input  logic  act_in,
	input  word_t xx_in,
	input  word_t yy_in,
	input  word_t cx_in,
	input  word_t cy_in,
	input  logic  ovf_in,
	output word_t xx_out,
	output word_t yy_out,
	output word_t cx_out,
	output word_t cy_out,
	output logic  ovf_out
);
	localparam int PW = 2 * WORD_W;
	localparam logic [PW:0] LIM = (PW+1)'(1) << (WORD_W - 1 + FRAC_BITS);

	// stage 1: magnitudes of the squares and the cross product
	logic [PW-1:0] sq_x_s1, sq_y_s1, xy_s1;
	logic neg_s1, act_s1, ovf_s1;
	word_t cx_s1, cy_s1, xx_s1, yy_s1;
	logic [WORD_W-1:0] mx, my;
	assign mx = xx_in[WORD_W-1] ? WORD_W'(-xx_in) : WORD_W'(xx_in);
	assign my = yy_in[WORD_W-1] ? WORD_W'(-yy_in) : WORD_W'(yy_in);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s1 <= PW'(mx) * PW'(mx);
			sq_y_s1 <= PW'(my) * PW'(my);
			xy_s1   <= PW'(mx) * PW'(my);
			neg_s1  <= xx_in[WORD_W-1] ^ yy_in[WORD_W-1];
			act_s1  <= act_in;
			ovf_s1  <= ovf_in;
			cx_s1 <= cx_in;
			cy_s1 <= cy_in;
			xx_s1 <= xx_in;
			yy_s1 <= yy_in;
		end
	end

	// stage 2: shift, floor and saturate each product
	word_t x2_s2, y2_s2, p_s2, cx_s2, cy_s2, xx_s2, yy_s2;
	logic act_s2, ovf_s2;
	logic [PW:0] qx2, qy2, qxy, qxyn;
	logic rem_xy;
	word_t x2_n, y2_n, p_n;
	logic o_m;
	always_comb begin
		qx2 = (PW+1)'(sq_x_s1 >> FRAC_BITS);
		qy2 = (PW+1)'(sq_y_s1 >> FRAC_BITS);
		qxy = (PW+1)'(xy_s1 >> (FRAC_BITS - 1));
		rem_xy = |(xy_s1 & ((PW'(1) << (FRAC_BITS - 1)) - PW'(1)));
		o_m = 1'b0;
		if (qx2 >= LIM >> FRAC_BITS) begin
			x2_n = Q_MAX;
			o_m = 1'b1;
		end else begin
			x2_n = qx2[WORD_W-1:0];
		end
		if (qy2 >= LIM >> FRAC_BITS) begin
			y2_n = Q_MAX;
			o_m = 1'b1;
		end else begin
			y2_n = qy2[WORD_W-1:0];
		end
		qxyn = qxy + (PW+1)'(rem_xy);
		if (neg_s1) begin
			if (qxyn > (LIM >> FRAC_BITS)) begin
				p_n = Q_MIN;
				o_m = 1'b1;
			end else begin
				p_n = WORD_W'(-qxyn[WORD_W:0]);
			end
		end else begin
			if (qxy >= (LIM >> FRAC_BITS)) begin
				p_n = Q_MAX;
				o_m = 1'b1;
			end else begin
				p_n = qxy[WORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s2 <= x2_n;
			y2_s2 <= y2_n;
			p_s2  <= p_n;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			xx_s2 <= xx_s1;
			yy_s2 <= yy_s1;
			act_s2 <= act_s1;
			ovf_s2 <= ovf_s1 | (act_s1 & o_m);
		end
	end

	// stage 3: sums and final saturation; an inactive step passes z through
	logic o_a, o_b;
	word_t nx, ny;
	always_comb begin
		nx = sat_w(QW'(x2_s2) - QW'(y2_s2) + QW'(cx_s2), o_a);
		ny = sat_w(QW'(p_s2) + QW'(cy_s2), o_b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_out <= act_s2 ? nx : xx_s2;
			yy_out <= act_s2 ? ny : yy_s2;
			cx_out <= cx_s2;
			cy_out <= cy_s2;
			ovf_out <= ovf_s2 | (act_s2 & (o_a | o_b));
		end
	end
endmodule

// File: hdl/mcw_div.sv
// pipelined restoring divider and wrap remainder units, one bit per stage
// depends on mcw_pkg; floor quotient by a signed step, floor remainder by a positive size
module mcw_div import mcw_pkg::*; #(
	parameter int NW = 48,
	parameter int TW = 8
) (
	input  logic clk,
	input  logic en,
	input  logic signed [NW-1:0] num,
	input  word_t den,
	input  logic [TW-1:0] tag_in,
	output logic signed [NW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	localparam int DW = WORD_W;

	logic [NW-1:0] q_s [NW+1];
	logic [NW+DW-1:0] r_s [NW+1];
	logic [DW-1:0] d_s [NW+1];
	logic neg_s [NW+1];
	logic [TW-1:0] t_s [NW+1];
	logic [NW-1:0] mn;
	assign mn = num[NW-1] ? NW'(-num) : NW'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0] <= mn;
			r_s[0] <= '0;
			d_s[0] <= den[DW-1] ? DW'(-den) : DW'(den);
			neg_s[0] <= num[NW-1] ^ den[DW-1];
			t_s[0] <= tag_in;
		end
	end

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [NW+DW-1:0] sh;
		logic ge;
		assign sh = {r_s[i][NW+DW-2:0], q_s[i][NW-1]};
		assign ge = sh >= (NW+DW)'(d_s[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1] <= ge ? sh - (NW+DW)'(d_s[i]) : sh;
				q_s[i+1] <= {q_s[i][NW-2:0], ge};
				d_s[i+1] <= d_s[i];
				neg_s[i+1] <= neg_s[i];
				t_s[i+1] <= t_s[i];
			end
		end
	end

	// floor for a negative quotient with a remainder
	logic [NW-1:0] qf;
	assign qf = q_s[NW] + NW'(neg_s[NW] && (r_s[NW] != '0));
	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[NW] ? NW'(-qf) : qf;
			tag_out <= t_s[NW];
		end
	end
endmodule

// floor remainder of a signed number by a positive divisor
module mcw_mod #(
	parameter int NW = 39,
	parameter int DW = 15,
	parameter int TW = 8
) (
	input  logic clk,
	input  logic en,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic [DW-1:0] rem,
	output logic [TW-1:0] tag_out
);
	logic [NW-1:0] n_s [NW];
	logic [DW-1:0] r_s [NW+1];
	logic [DW-1:0] d_s [NW+1];
	logic neg_s [NW+1];
	logic [TW-1:0] t_s [NW+1];
	logic [NW-1:0] mn;
	assign mn = num[NW-1] ? NW'(-num) : NW'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= mn;
			r_s[0] <= '0;
			d_s[0] <= den;
			neg_s[0] <= num[NW-1];
			t_s[0] <= tag_in;
		end
	end

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW:0] sh;
		logic ge;
		assign sh = {r_s[i], n_s[i][NW-1]};
		assign ge = sh >= {1'b0, d_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1] <= ge ? DW'(sh - {1'b0, d_s[i]}) : DW'(sh);
				d_s[i+1] <= d_s[i];
				neg_s[i+1] <= neg_s[i];
				t_s[i+1] <= t_s[i];
			end
		end
		if (i < NW - 1) begin : g_sh
			always_ff @(posedge clk) begin
				if (en) n_s[i+1] <= {n_s[i][NW-2:0], 1'b0};
			end
		end
	end

	// a negative number with a remainder folds back into 0..den-1
	logic [DW-1:0] rf;
	assign rf = (neg_s[NW] && (r_s[NW] != '0)) ? d_s[NW] - r_s[NW] : r_s[NW];
	always_ff @(posedge clk) begin
		if (en) begin
			rem <= rf;
			tag_out <= t_s[NW];
		end
	end
endmodule

// File: hdl/mandelbrot_coordinate_warp.sv
// channel  dir  payload
// cfg      in   index, wdata (register write)
// pix      in   pixel_col, pixel_row
// res      out  outcome, sample_col, sample_row, frac_col, frac_row, overflowed
// one item per cycle while the output is not stalled
// the depth is set by the unrolled update steps, the bit-serial divider stages
// and the wrap remainder stages
// a stall freezes the whole pipe; input ready follows output ready or an empty last stage
// reset clears valid bits and loads the register defaults
// depends on mcw_pkg, mcw_if, mcw_cfg_if, mcw_iter, mcw_div, mcw_mod and the macro header
`include "mandelbrot_coordinate_warp_macros.svh"
module mandelbrot_coordinate_warp import mcw_pkg::*; #(
	parameter int MAX_DEPTH = 64,
	parameter int FRAC_BITS = 24,
	parameter int MAX_DIM = 16384
) (
	input logic clk,
	input logic arst_n,
	mcw_cfg_if.sink cfg,
	mcw_if.sink pix,
	mcw_if.source res
);
	localparam int DEP_W = $clog2(MAX_DEPTH + 1);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int NW = WORD_W + 11;
	localparam int LAT = 3 * MAX_DEPTH + 2 * NW + 1;

	word_t xb_q, yb_q, xs_q, ys_q;
	logic [6:0] depth_q;
	logic [1:0] mode_q;
	logic [14:0] w_q, h_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xb_q <= -(WORD_W'(1) << FRAC_BITS);
			yb_q <= -(WORD_W'(1) << FRAC_BITS);
			xs_q <= WORD_W'(1) << (FRAC_BITS - 8);
			ys_q <= WORD_W'(1) << (FRAC_BITS - 8);
			depth_q <= 7'd3;
			mode_q <= OUT_SAMPLE;
			w_q <= 15'd256;
			h_q <= 15'd256;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_X_BASE: xb_q <= cfg.wdata;
				REG_Y_BASE: yb_q <= cfg.wdata;
				REG_X_STEP: xs_q <= cfg.wdata;
				REG_Y_STEP: ys_q <= cfg.wdata;
				REG_DEPTH: depth_q <= cfg.wdata[6:0];
				REG_MODE: mode_q <= cfg.wdata[1:0];
				REG_WIDTH: w_q <= cfg.wdata[14:0];
				REG_HEIGHT: h_q <= cfg.wdata[14:0];
				default: ;
			endcase
		end
	end

	// pipeline control: a single valid shift line, frozen on stall
	logic [LAT-1:0] vld_q;
	logic en;
	assign en = res.ready | ~vld_q[LAT-1];
	assign pix.ready = en;
	assign res.valid = vld_q[LAT-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], pix.valid};
	end

	logic [DEP_W-1:0] depth_eff;
	assign depth_eff = (int'(depth_q) > MAX_DEPTH) ? DEP_W'(MAX_DEPTH) : DEP_W'(depth_q);
	logic [DIM_W-1:0] wd, hd;
	assign wd = (w_q == '0) ? DIM_W'(1) : (int'(w_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(w_q);
	assign hd = (h_q == '0) ? DIM_W'(1) : (int'(h_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(h_q);

	// stage s1: products coordinate times step
	logic signed [WORD_W+COORD_W:0] px_s1, py_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed({1'b0, pix.data[COORD_W-1:0]}) * xs_q;
			py_s1 <= $signed({1'b0, pix.data[2*COORD_W-1:COORD_W]}) * ys_q;
		end
	end
	// stage s2: add base and saturate
	word_t cx_s2, cy_s2;
	logic ovf_s2;
	logic oa, ob;
	word_t cxn, cyn;
	always_comb begin
		cxn = sat_w(QW'(px_s1) + QW'(xb_q), oa);
		cyn = sat_w(QW'(py_s1) + QW'(yb_q), ob);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2 <= cxn;
			cy_s2 <= cyn;
			ovf_s2 <= oa | ob;
		end
	end

	word_t xx_c [MAX_DEPTH+1], yy_c [MAX_DEPTH+1], cx_c [MAX_DEPTH+1], cy_c [MAX_DEPTH+1];
	logic ovf_c [MAX_DEPTH+1];
	assign xx_c[0] = cx_s2;
	assign yy_c[0] = cy_s2;
	assign cx_c[0] = cx_s2;
	assign cy_c[0] = cy_s2;
	assign ovf_c[0] = ovf_s2;

	for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_it
		mcw_iter #(.FRAC_BITS(FRAC_BITS)) u_it (
			.clk(clk), .en(en), .act_in(DEP_W'(k) < depth_eff),
			.xx_in(xx_c[k]), .yy_in(yy_c[k]), .cx_in(cx_c[k]), .cy_in(cy_c[k]),
			.ovf_in(ovf_c[k]),
			.xx_out(xx_c[k+1]), .yy_out(yy_c[k+1]), .cx_out(cx_c[k+1]),
			.cy_out(cy_c[k+1]), .ovf_out(ovf_c[k+1])
		);
	end

	// numerators (z - base) * 256, stage s3
	logic signed [NW-1:0] nx_s3, ny_s3;
	logic zx_s3, zy_s3, ovf_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3 <= (NW'(xx_c[MAX_DEPTH]) - NW'(xb_q)) <<< 8;
			ny_s3 <= (NW'(yy_c[MAX_DEPTH]) - NW'(yb_q)) <<< 8;
			zx_s3 <= xs_q == '0;
			zy_s3 <= ys_q == '0;
			ovf_s3 <= ovf_c[MAX_DEPTH];
		end
	end

	// a zero step gives coordinate zero; the divider tags carry that flag
	logic signed [NW-1:0] qx_d, qy_d;
	logic ovf_d, zx_d, zy_d;
	mcw_div #(.NW(NW), .TW(2)) u_divx (
		.clk(clk), .en(en), .num(nx_s3), .den(zx_s3 ? WORD_W'(1) : xs_q),
		.tag_in({ovf_s3 | zx_s3 | zy_s3, zx_s3}), .quo(qx_d), .tag_out({ovf_d, zx_d})
	);
	mcw_div #(.NW(NW), .TW(1)) u_divy (
		.clk(clk), .en(en), .num(ny_s3), .den(zy_s3 ? WORD_W'(1) : ys_q),
		.tag_in(zy_s3), .quo(qy_d), .tag_out(zy_d)
	);
	logic signed [NW-1:0] qx, qy;
	assign qx = zx_d ? '0 : qx_d;
	assign qy = zy_d ? '0 : qy_d;

	// stage: inside test
	logic signed [NW-1:0] wq, hq;
	assign wq = NW'({wd, 8'd0});
	assign hq = NW'({hd, 8'd0});
	logic signed [NW-1:0] qx_e, qy_e;
	logic in_e, ovf_e;
	always_ff @(posedge clk) begin
		if (en) begin
			qx_e <= qx;
			qy_e <= qy;
			in_e <= (qx >= 0) && (qx < wq) && (qy >= 0) && (qy < hq);
			ovf_e <= ovf_d;
		end
	end

	// wrap: floor remainder of the whole-pixel part by the image size, fraction kept;
	// an inside point passes through unchanged
	logic [DIM_W-1:0] rmx, rmy;
	logic [FRAC_W+1:0] tag_mx;
	logic [FRAC_W-1:0] fc_m, fr_m;
	logic in_m, ovf_m;
	mcw_mod #(.NW(NW-8), .DW(DIM_W), .TW(FRAC_W+2)) u_modx (
		.clk(clk), .en(en), .num($signed(qx_e[NW-1:8])), .den(wd),
		.tag_in({in_e, ovf_e, qx_e[7:0]}), .rem(rmx), .tag_out(tag_mx)
	);
	mcw_mod #(.NW(NW-8), .DW(DIM_W), .TW(FRAC_W)) u_mody (
		.clk(clk), .en(en), .num($signed(qy_e[NW-1:8])), .den(hd),
		.tag_in(qy_e[7:0]), .rem(rmy), .tag_out(fr_m)
	);
	assign {in_m, ovf_m, fc_m} = tag_mx;

	logic [1:0] oc_q;
	logic [COORD_W-1:0] sc_q, sr_q;
	logic [FRAC_W-1:0] fc_q, fr_q;
	logic ov_q;
	always_ff @(posedge clk) begin
		if (en) begin
			ov_q <= ovf_m;
			if (in_m || mode_q == OUT_SAMPLE) begin
				oc_q <= OUT_SAMPLE;
				sc_q <= COORD_W'(rmx);
				sr_q <= COORD_W'(rmy);
				fc_q <= fc_m;
				fr_q <= fr_m;
			end else begin
				oc_q <= mode_q;
				sc_q <= '0;
				sr_q <= '0;
				fc_q <= '0;
				fr_q <= '0;
			end
		end
	end
	assign res.data = {ov_q, fr_q, fc_q, sr_q, sc_q, oc_q};

	`MCW_ASSERT_NEXT(a_stall_hold, clk, arst_n, res.valid && !res.ready, res.valid,
		"result lost during stall")
	`MCW_ASSERT(a_fill_zero, clk, arst_n, !res.valid || oc_q == OUT_SAMPLE ||
		(sc_q == '0 && sr_q == '0 && fc_q == '0 && fr_q == '0), "fill with nonzero fields")
	`MCW_ASSERT(a_ready, clk, arst_n, res.valid || pix.ready, "ready low with empty output")
endmodule

// File: verif/mandelbrot_coordinate_warp_tb.sv
// self-checking testbench for the mandelbrot coordinate warp block
// predicts each result in a scoreboard class, drives cfg, pix and res channels
// depends on mcw_pkg, mcw_if, mcw_cfg_if and the block itself
`timescale 1ns / 100ps
module mandelbrot_coordinate_warp_tb;
	import mcw_pkg::*;

	localparam int DEPTH_CAP = 64;
	localparam int FRAC_SH = 24;
	localparam int DIM_CAP = 16384;
	localparam int PIPE_WAIT = 600;
	localparam longint WMAX = 64'sd34359738367;
	localparam longint WMIN = -64'sd34359738368;

	typedef struct packed {
		logic overflowed;
		logic [7:0] frac_row;
		logic [7:0] frac_col;
		logic [13:0] sample_row;
		logic [13:0] sample_col;
		logic [1:0] outcome;
	} warp_res_t;

	class warp_scoreboard;
		logic [35:0] regs [8];
		warp_res_t pending [$];
		int fails;
		bit ovf;

		function new();
			regs[REG_X_BASE] = -36'sd16777216;
			regs[REG_Y_BASE] = -36'sd16777216;
			regs[REG_X_STEP] = 36'd65536;
			regs[REG_Y_STEP] = 36'd65536;
			regs[REG_DEPTH] = 36'd3;
			regs[REG_MODE] = 36'd0;
			regs[REG_WIDTH] = 36'd256;
			regs[REG_HEIGHT] = 36'd256;
			fails = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [35:0] v);
			unique case (idx)
				REG_DEPTH: regs[idx] = 36'(v[6:0]);
				REG_MODE: regs[idx] = 36'(v[1:0]);
				REG_WIDTH, REG_HEIGHT: regs[idx] = 36'(v[14:0]);
				default: regs[idx] = v;
			endcase
		endfunction

		function longint sx36(logic [35:0] v);
			return longint'(signed'(v));
		endfunction

		function longint clip(longint v);
			if (v > WMAX) begin
				ovf = 1;
				return WMAX;
			end
			if (v < WMIN) begin
				ovf = 1;
				return WMIN;
			end
			return v;
		endfunction

		// exact product, floor shift, then clip
		function longint mul_floor(longint a, longint b, int sh);
			logic signed [79:0] pa, pb, p;
			pa = a;
			pb = b;
			p = (pa * pb) >>> sh;
			if (p > 80'sd34359738367) begin
				ovf = 1;
				return WMAX;
			end
			if (p < -80'sd34359738368) begin
				ovf = 1;
				return WMIN;
			end
			return longint'(p);
		endfunction

		function longint fdiv(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d != 0) && ((n < 0) != (d < 0)))
				q -= 1;
			return q;
		endfunction

		function longint dim(logic [35:0] v);
			if (v == 0)
				return 1;
			if (v > DIM_CAP)
				return DIM_CAP;
			return longint'(v);
		endfunction

		function void note_pixel(logic [13:0] col, logic [13:0] row);
			longint bx, by, stx, sty, cx, cy, xx, yy, x2, y2, xy, qx, qy, wq, hq;
			int depth;
			bit in_img;
			warp_res_t r;
			ovf = 0;
			bx = sx36(regs[REG_X_BASE]);
			by = sx36(regs[REG_Y_BASE]);
			stx = sx36(regs[REG_X_STEP]);
			sty = sx36(regs[REG_Y_STEP]);
			cx = clip(bx + longint'(col) * stx);
			cy = clip(by + longint'(row) * sty);
			xx = cx;
			yy = cy;
			depth = (regs[REG_DEPTH] > DEPTH_CAP) ? DEPTH_CAP : int'(regs[REG_DEPTH]);
			for (int k = 0; k < depth; k++) begin
				x2 = mul_floor(xx, xx, FRAC_SH);
				y2 = mul_floor(yy, yy, FRAC_SH);
				xy = mul_floor(xx, yy, FRAC_SH - 1);
				xx = clip(x2 - y2 + cx);
				yy = clip(xy + cy);
			end
			if (stx == 0) begin
				qx = 0;
				ovf = 1;
			end else
				qx = fdiv((xx - bx) * 256, stx);
			if (sty == 0) begin
				qy = 0;
				ovf = 1;
			end else
				qy = fdiv((yy - by) * 256, sty);
			wq = dim(regs[REG_WIDTH]) * 256;
			hq = dim(regs[REG_HEIGHT]) * 256;
			in_img = qx >= 0 && qx < wq && qy >= 0 && qy < hq;
			if (!in_img && outcome_t'(regs[REG_MODE][1:0]) == OUT_SAMPLE) begin
				qx %= wq;
				if (qx < 0)
					qx += wq;
				qy %= hq;
				if (qy < 0)
					qy += hq;
				in_img = 1;
			end
			if (in_img) begin
				r.outcome = OUT_SAMPLE;
				r.sample_col = qx[21:8];
				r.sample_row = qy[21:8];
				r.frac_col = qx[7:0];
				r.frac_row = qy[7:0];
			end else begin
				r.outcome = regs[REG_MODE][1:0];
				r.sample_col = '0;
				r.sample_row = '0;
				r.frac_col = '0;
				r.frac_row = '0;
			end
			r.overflowed = ovf;
			pending.push_back(r);
		endfunction

		function void check_result(warp_res_t got);
			warp_res_t e;
			if (pending.size() == 0) begin
				$error("result with nothing pending: %h", got);
				fails++;
				return;
			end
			e = pending.pop_front();
			if (got.outcome !== e.outcome) begin
				$error("outcome exp %0d got %0d", e.outcome, got.outcome);
				fails++;
			end
			if (got.sample_col !== e.sample_col) begin
				$error("sample_col exp %0d got %0d", e.sample_col, got.sample_col);
				fails++;
			end
			if (got.sample_row !== e.sample_row) begin
				$error("sample_row exp %0d got %0d", e.sample_row, got.sample_row);
				fails++;
			end
			if (got.frac_col !== e.frac_col) begin
				$error("frac_col exp %0d got %0d", e.frac_col, got.frac_col);
				fails++;
			end
			if (got.frac_row !== e.frac_row) begin
				$error("frac_row exp %0d got %0d", e.frac_row, got.frac_row);
				fails++;
			end
			if (got.overflowed !== e.overflowed) begin
				$error("overflowed exp %0d got %0d", e.overflowed, got.overflowed);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	warp_scoreboard warp_sb;

	mcw_cfg_if cfg_ch (clk);
	mcw_if #(28) pix_ch (clk);
	mcw_if #(47) res_ch (clk);

	mandelbrot_coordinate_warp uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.pix(pix_ch),
		.res(res_ch)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stall per item
	initial begin
		int n;
		res_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (n > 0) begin
				res_ch.ready <= 0;
				repeat (n) @(posedge clk);
			end
			res_ch.ready <= 1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	always @(posedge clk)
		if (arst_n && res_ch.valid && res_ch.ready)
			warp_sb.check_result(warp_res_t'(res_ch.data));

	task automatic write_reg(cfg_reg_t idx, logic [35:0] v);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		warp_sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic send_pixel(logic [13:0] col, logic [13:0] row, bit idle_ok);
		int n;
		n = idle_ok ? $urandom_range(0, 17) : 0;
		if (n > 0) begin
			pix_ch.valid <= 0;
			repeat (n) @(posedge clk);
		end
		pix_ch.valid <= 1;
		pix_ch.data <= {row, col};
		do @(posedge clk); while (!pix_ch.ready);
		warp_sb.note_pixel(col, row);
	endtask

	task automatic drain();
		pix_ch.valid <= 0;
		while (warp_sb.pending.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [35:0] pick_base();
		case ($urandom_range(0, 7))
			0: return 36'h800000000;
			1: return 36'h7ffffffff;
			2: return 36'({$urandom(), $urandom()});
			default: return 36'(longint'($urandom_range(0, 1 << 26)) - (longint'(1) << 25));
		endcase
	endfunction

	function automatic logic [35:0] pick_step();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return 36'h800000000;
			2: return 36'h7ffffffff;
			3: return 36'({$urandom(), $urandom()});
			4: return 36'(-longint'($urandom_range(1, 1 << 18)));
			default: return 36'($urandom_range(1, 1 << 18));
		endcase
	endfunction

	function automatic logic [35:0] pick_dim();
		case ($urandom_range(0, 7))
			0: return 36'd0;
			1: return 36'd16384;
			2: return 36'd32767;
			3: return 36'($urandom_range(0, 32767));
			default: return 36'($urandom_range(1, 400));
		endcase
	endfunction

	function automatic logic [35:0] pick_depth();
		case ($urandom_range(0, 9))
			0: return 36'd64;
			1: return 36'd65;
			2: return 36'd127;
			3: return 36'($urandom_range(0, 127));
			default: return 36'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic config_all(logic [35:0] xb, logic [35:0] yb, logic [35:0] xs,
			logic [35:0] ys, logic [35:0] dp, logic [35:0] md, logic [35:0] w,
			logic [35:0] h);
		write_reg(REG_X_BASE, xb);
		write_reg(REG_Y_BASE, yb);
		write_reg(REG_X_STEP, xs);
		write_reg(REG_Y_STEP, ys);
		write_reg(REG_DEPTH, dp);
		write_reg(REG_MODE, md);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	initial begin
		logic [13:0] c, r;
		warp_sb = new();
		arst_n = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = REG_X_BASE;
		cfg_ch.wdata = '0;
		pix_ch.valid = 0;
		pix_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings, corner coordinates
		send_pixel(14'd0, 14'd0, 1'b0);
		send_pixel(14'h3fff, 14'h3fff, 1'b0);
		send_pixel(14'd255, 14'd255, 1'b1);
		send_pixel(14'd256, 14'd0, 1'b0);
		send_pixel(14'd0, 14'h3fff, 1'b1);
		send_pixel(14'd128, 14'd77, 1'b0);
		drain();

		// identity map, each outside handling, inside and outside points
		for (int m = 0; m < 4; m++) begin
			config_all(36'd0, 36'd0, 36'd65536, -36'sd65536, 36'd0, 36'(m), 36'd100, 36'd0);
			send_pixel(14'd50, 14'd0, 1'b0);
			send_pixel(14'd150, 14'd0, 1'b0);
			send_pixel(14'd99, 14'h3fff, 1'b1);
			drain();
		end
		// extremes: zero step, saturated base, deep iteration, oversized dims
		config_all(36'h7ffffffff, 36'h800000000, 36'd0, 36'h7ffffffff, 36'd127, 36'd1,
			36'd32767, 36'd16384);
		send_pixel(14'd0, 14'd0, 1'b0);
		send_pixel(14'h3fff, 14'd1, 1'b0);
		send_pixel(14'd1, 14'h3fff, 1'b1);
		drain();
		config_all(36'h800000000, 36'h7ffffffff, 36'h800000000, 36'd0, 36'd64, 36'd0,
			36'd0, 36'd1);
		send_pixel(14'h2aaa, 14'h1555, 1'b0);
		send_pixel(14'd3, 14'd9, 1'b0);
		drain();

		for (int ph = 0; ph < 27; ph++) begin
			config_all(pick_base(), pick_base(), pick_step(), pick_step(), pick_depth(),
				36'($urandom_range(0, 3)), pick_dim(), pick_dim());
			for (int i = 0; i < 50; i++) begin
				c = ($urandom_range(0, 3) == 0) ? 14'($urandom()) : 14'($urandom_range(0, 400));
				r = ($urandom_range(0, 3) == 0) ? 14'($urandom()) : 14'($urandom_range(0, 400));
				send_pixel(c, r, ph % 4 != 1);
			end
			drain();
		end

		repeat (PIPE_WAIT) @(posedge clk);
		if (warp_sb.fails == 0 && warp_sb.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: mandelbrot_coordinate_warp.f
+incdir+hdl
hdl/mcw_pkg.sv
hdl/mcw_if.sv
hdl/mcw_cfg_if.sv
hdl/mcw_iter.sv
hdl/mcw_div.sv
hdl/mandelbrot_coordinate_warp.sv
verif/mandelbrot_coordinate_warp_tb.sv
